FILE: rtl/core/psd_pkg.sv
package psd_pkg;

   // default geometry
   localparam int DEPTH_DEF  = 128;
   localparam int DATA_W_DEF = 32;

   // fixed field widths
   localparam int OP_W     = 1;
   localparam int STATUS_W = 2;
   localparam int CFG_W    = 8;
   localparam int OCC_W    = 8;

   // capacity after reset
   localparam logic [CFG_W-1:0] CAP_RESET = 8'd128;

   // operation codes
   localparam logic [OP_W-1:0] OP_PUSH = 1'b0;
   localparam logic [OP_W-1:0] OP_POP  = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic capture;   // latch the request beat
      logic exec;      // evaluate push or pop against head and count
      logic pop_done;  // read data is back, finish the pop
   } ctl_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic need_read; // pop on a non-empty deque, read issued this cycle
   } dp_status_type;

endpackage

FILE: rtl/core/psd_ram.sv
module psd_ram
   import psd_pkg::*;
#(
   parameter int WIDTH = DATA_W_DEF,
   parameter int DEPTH = DEPTH_DEF,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // single write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/psd_ctrl.sv
module psd_ctrl
   import psd_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   output logic          busy,
   output ctl_cmd_type   cmd,
   input  dp_status_type status
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_EXEC  = 2'd1;
   localparam logic [1:0] S_POPRD = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            state_in = status.need_read ? S_POPRD : S_IDLE;
         end
         S_POPRD: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // command decode
   assign busy         = (state_ff != S_IDLE);
   assign cmd.capture  = (state_ff == S_IDLE) && start;
   assign cmd.exec     = (state_ff == S_EXEC);
   assign cmd.pop_done = (state_ff == S_POPRD);

endmodule

FILE: rtl/core/psd_datapath.sv
module psd_datapath
   import psd_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_W_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  ctl_cmd_type           cmd,
   output dp_status_type         status,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [DATA_WIDTH-1:0] req_value,
   input  logic                  csr_wr,
   input  logic [CFG_W-1:0]      csr_data,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [DATA_WIDTH-1:0] rsp_popped_value,
   output logic [OCC_W-1:0]      rsp_occupancy
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = CW + 1;
   localparam int LW = (CW > CFG_W) ? CW : CFG_W;

   logic [OP_W-1:0]       op_ff;
   logic [DATA_WIDTH-1:0] value_ff;
   logic [AW-1:0]         head_ff, head_in;
   logic [CW-1:0]         count_ff, count_in;
   logic [CFG_W-1:0]      cap_ff;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [DATA_WIDTH-1:0] rsp_popped_ff, rsp_popped_in;
   logic [OCC_W-1:0]      rsp_occ_ff, rsp_occ_in;

   logic [SW-1:0]         slot_sum;
   logic [AW-1:0]         back_slot;
   logic [AW-1:0]         head_dec;
   logic [AW-1:0]         head_inc;
   logic                  is_pop;
   logic                  full;
   logic                  empty;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [DATA_WIDTH-1:0] rd_data;

   // ring arithmetic, one compare and one add or subtract each
   assign slot_sum  = SW'(head_ff) + SW'(count_ff);
   assign back_slot = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH)) : AW'(slot_sum);
   assign head_dec  = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);
   assign head_inc  = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + AW'(1);

   // limit is the smaller of capacity and depth
   assign is_pop = (op_ff == OP_POP);
   assign full   = (LW'(count_ff) >= LW'(cap_ff)) || (count_ff == CW'(DEPTH));
   assign empty  = (count_ff == '0);

   assign status.need_read = cmd.exec && is_pop && !empty;

   // ring write: even to the back, odd to the front
   assign wr_en   = cmd.exec && !is_pop && !full;
   assign wr_addr = value_ff[0] ? head_dec : back_slot;

   psd_ram #(
      .WIDTH (DATA_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (value_ff),
      .rd_en   (status.need_read),
      .rd_addr (head_ff),
      .rd_data (rd_data)
   );

   // head, count and response next values
   always_comb begin
      head_in       = head_ff;
      count_in      = count_ff;
      rsp_valid_in  = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_popped_in = rsp_popped_ff;
      rsp_occ_in    = rsp_occ_ff;
      priority if (cmd.pop_done) begin
         head_in       = head_inc;
         count_in      = count_ff - CW'(1);
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_OK;
         rsp_popped_in = rd_data;
         rsp_occ_in    = OCC_W'(count_ff - CW'(1));
      end else if (cmd.exec && !is_pop) begin
         rsp_valid_in  = 1'b1;
         rsp_popped_in = '0;
         if (full) begin
            rsp_status_in = ST_FULL;
            rsp_occ_in    = OCC_W'(count_ff);
         end else begin
            if (value_ff[0]) head_in = head_dec;
            count_in      = count_ff + CW'(1);
            rsp_status_in = ST_OK;
            rsp_occ_in    = OCC_W'(count_ff + CW'(1));
         end
      end else if (cmd.exec && empty) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = ST_EMPTY;
         rsp_popped_in = '0;
         rsp_occ_in    = OCC_W'(count_ff);
      end else begin
         // pop read in flight or idle
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         count_ff     <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         head_ff      <= head_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) cap_ff <= csr_data;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_operation;
         value_ff <= req_value;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_popped_ff <= rsp_popped_in;
      rsp_occ_ff    <= rsp_occ_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_popped_value = rsp_popped_ff;
   assign rsp_occupancy    = rsp_occ_ff;

   // count never passes the ring depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // a result strobe lasts a single cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("result strobe held two cycles");

   // accepted push grows the count by one
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.exec && !is_pop && !full) |=> (count_ff == $past(count_ff) + CW'(1)))
      else $error("push did not advance count");

   // successful pop shrinks the count by one
   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_done |=> (count_ff == $past(count_ff) - CW'(1)))
      else $error("pop did not reduce count");

endmodule

FILE: rtl/core/parity_steered_deque_core.sv
// Push: start accepted in idle, request captured; the execute state loads the result strobe.
// Pop on a non-empty deque: execute issues the RAM read, the pop-read state loads the strobe;
// pop on an empty deque: the execute state loads the strobe, as for a push.
// A new request is taken only in idle; a non-empty pop also passes through the pop-read state.
// busy stays high from accept until the result registers load; results cannot stall.
// Synchronous reset clears head, count, controller and strobe; capacity returns to 128.
// Ring RAM contents are not cleared; only written slots are ever read.
module parity_steered_deque_core
   import psd_pkg::*;
#(
   parameter int DEPTH      = DEPTH_DEF,
   parameter int DATA_WIDTH = DATA_W_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [DATA_WIDTH-1:0] req_value,
   // result channel
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [DATA_WIDTH-1:0] rsp_popped_value,
   output logic [OCC_W-1:0]      rsp_occupancy,
   // capacity register write
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CFG_W-1:0]      csr_data
);

   ctl_cmd_type   cmd;
   dp_status_type status;

   // config writes always taken
   assign csr_ready = 1'b1;

   psd_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .cmd    (cmd),
      .status (status)
   );

   psd_datapath #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_operation    (req_operation),
      .req_value        (req_value),
      .csr_wr           (csr_valid && csr_ready),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_popped_value (rsp_popped_value),
      .rsp_occupancy    (rsp_occupancy)
   );

endmodule
